>>> rtl/tnss_pkg.sv
package tnss_pkg;

  // Input item kinds
  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_START = 2'd1,
    KIND_STOP  = 2'd2,
    KIND_LOAD  = 2'd3
  } kind_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FRAMES_PER_STEP = 2'd0,
    CFG_NUM_STEPS       = 2'd1,
    CFG_LOOP_ENABLE     = 2'd2
  } cfg_reg_t;

  localparam logic [7:0] NOTE_HOLD    = 8'd255;
  localparam logic [7:0] NOTE_SILENT  = 8'd0;
  localparam logic       CHANNEL_LEAD = 1'b0;
  localparam logic       CHANNEL_BASS = 1'b1;

  // Note number to channel frequency register value; zero means no tone
  localparam logic [10:0] NOTE_CODE [128] = '{
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,    11'd0,
    11'd44,   11'd157,  11'd263,  11'd363,  11'd457,  11'd547,
    11'd631,  11'd711,  11'd786,  11'd856,  11'd923,  11'd986,
    11'd1046, 11'd1102, 11'd1155, 11'd1205, 11'd1253, 11'd1297,
    11'd1339, 11'd1379, 11'd1417, 11'd1452, 11'd1486, 11'd1517,
    11'd1547, 11'd1575, 11'd1602, 11'd1627, 11'd1650, 11'd1673,
    11'd1694, 11'd1714, 11'd1732, 11'd1750, 11'd1767, 11'd1783,
    11'd1798, 11'd1812, 11'd1825, 11'd1837, 11'd1849, 11'd1860,
    11'd1871, 11'd1881, 11'd1890, 11'd1899, 11'd1907, 11'd1915,
    11'd1923, 11'd1930, 11'd1936, 11'd1943, 11'd1949, 11'd1954,
    11'd1959, 11'd1964, 11'd1969, 11'd1974, 11'd1978, 11'd1982,
    11'd1985, 11'd1989, 11'd1992, 11'd1995, 11'd1998, 11'd2001,
    11'd2004, 11'd2006, 11'd2009, 11'd2011, 11'd2013, 11'd2015,
    11'd2017, 11'd2018, 11'd2020, 11'd2022, 11'd2023, 11'd2025,
    11'd2026, 11'd2027, 11'd2028, 11'd2029, 11'd2030, 11'd2031,
    11'd2032, 11'd2033, 11'd2034, 11'd2035, 11'd2036, 11'd2036,
    11'd2037, 11'd2038
  };

  // Pending retrigger job: one note per channel, hold code skips a channel
  typedef struct packed {
    logic [7:0] lead;
    logic [7:0] bass;
  } job_t;

  function automatic logic [10:0] note_code(input logic [7:0] note);
    logic [10:0] code;
    code = 11'd0;
    if (note != NOTE_SILENT && !note[7]) begin
      code = NOTE_CODE[note[6:0]];
    end
    return code;
  endfunction

endpackage

>>> rtl/tnss_emit.sv
module tnss_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             job_valid,
  input  tnss_pkg::job_t   job,
  output logic             job_done,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             channel,
  output logic             sounding,
  output logic [10:0]      freq_code,
  output logic             last
);

  logic        phase;
  logic        phase_next;
  logic        out_free;
  logic        lead_emit;
  logic        bass_emit;
  logic        want;
  logic        final_one;
  logic        emit_go;
  logic [7:0]  sel_note;
  logic [10:0] sel_code;
  logic        sel_channel;

  always_comb begin
    out_free  = !out_valid || out_ready;
    lead_emit = !phase && (job.lead != tnss_pkg::NOTE_HOLD);
    bass_emit = job.bass != tnss_pkg::NOTE_HOLD;
    want      = job_valid && (lead_emit || bass_emit);
    final_one = !lead_emit || !bass_emit;
    sel_note    = lead_emit ? job.lead : job.bass;
    sel_channel = lead_emit ? tnss_pkg::CHANNEL_LEAD : tnss_pkg::CHANNEL_BASS;
    sel_code    = tnss_pkg::note_code(sel_note);
    emit_go  = want && out_free;
    job_done = job_valid && (!want || (out_free && final_one));
    phase_next = phase;
    if (job_done) begin
      phase_next = 1'b0;
    end else if (emit_go) begin
      phase_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload: load the next retrigger when the output register frees up
  always_ff @(posedge clk) begin
    if (emit_go) begin
      channel   <= sel_channel;
      sounding  <= (sel_code != 11'd0);
      freq_code <= sel_code;
      last      <= final_one;
    end
  end

endmodule

>>> rtl/two_channel_note_step_sequencer_core.sv
// Flow: an accepted item's job register and read data load at the accepting edge; the
//   output register then loads the job's first result as soon as it is free.
// Throughput: one item per cycle unless out_ready stalls; a two-result item holds the
//   job stage longer, as the single output register carries one result per cycle.
// Reset: rst (synchronous) restores config (tempo 1, 0 steps, no loop), stops playback
//   and clears counters and valid flags; pattern memories keep their contents.
module two_channel_note_step_sequencer_core #(
  parameter int MAX_STEPS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  step_index,
  input  logic [7:0]  lead_note,
  input  logic [7:0]  bass_note,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        channel,
  output logic        sounding,
  output logic [10:0] freq_code,
  output logic        last
);

  // Address width of the pattern memories and width of the step position,
  // which must also hold MAX_STEPS itself.
  localparam int AW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int PW = $clog2(MAX_STEPS + 1);
  // Common width for comparing position, step count and load index
  localparam int XW = ((PW > 9) ? PW : 9) + 1;
  localparam logic [XW-1:0] MAX_X = XW'(MAX_STEPS);

  // Configuration registers
  logic [7:0] frames_per_step;
  logic [8:0] num_steps;
  logic       loop_enable;

  // Playback state
  logic          playing;
  logic [PW-1:0] step_position;
  logic [7:0]    frame_count;

  // Pattern memories and their registered read data
  logic [7:0] lead_mem [MAX_STEPS];
  logic [7:0] bass_mem [MAX_STEPS];
  logic [7:0] lead_rd;
  logic [7:0] bass_rd;

  // Job stage between the front end and the result serializer
  logic           job_valid;
  logic           job_silence;
  logic           job_done;
  tnss_pkg::job_t job;

  // Front-end decode
  logic          in_accept;
  tnss_pkg::kind_t kind_c;
  logic          playing_next;
  logic [PW-1:0] step_position_next;
  logic [7:0]    frame_count_next;
  logic          job_load;
  logic          job_silence_next;
  logic          mem_we;
  logic [AW-1:0] wr_addr;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [8:0]    fc_inc;
  logic [8:0]    tempo;
  logic [7:0]    fc_wrap;
  logic [XW-1:0] steps_x;
  logic [XW-1:0] len_x;
  logic [XW-1:0] pos_x;
  logic [XW-1:0] idx_x;
  logic          at_end;
  logic [PW-1:0] rd_pos;

  assign in_ready  = !job_valid || job_done;
  assign in_accept = in_valid && in_ready;
  assign kind_c    = tnss_pkg::kind_t'(kind);

  // Configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_step <= 8'd1;
      num_steps       <= 9'd0;
      loop_enable     <= 1'b0;
    end else if (cfg_wr_en) begin
      case (tnss_pkg::cfg_reg_t'(cfg_index))
        tnss_pkg::CFG_FRAMES_PER_STEP: frames_per_step <= cfg_data[7:0];
        tnss_pkg::CFG_NUM_STEPS:       num_steps       <= cfg_data;
        tnss_pkg::CFG_LOOP_ENABLE:     loop_enable     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    // Frame counter advances and wraps at the tempo; tempo 0 acts as 1
    fc_inc  = {1'b0, frame_count} + 9'd1;
    tempo   = (frames_per_step == 8'd0) ? 9'd1 : {1'b0, frames_per_step};
    fc_wrap = (fc_inc >= tempo) ? 8'd0 : fc_inc[7:0];

    // Effective pattern length: num_steps clamped to the memory depth
    steps_x = XW'(num_steps);
    len_x   = (steps_x > MAX_X) ? MAX_X : steps_x;
    pos_x   = XW'(step_position);
    at_end  = pos_x >= len_x;
    rd_pos  = at_end ? '0 : step_position;

    idx_x   = XW'(step_index);
    wr_addr = idx_x[AW-1:0];
    rd_addr = rd_pos[AW-1:0];

    playing_next       = playing;
    step_position_next = step_position;
    frame_count_next   = frame_count;
    job_load           = 1'b0;
    job_silence_next   = 1'b0;
    mem_we             = 1'b0;
    rd_en              = 1'b0;

    if (in_accept) begin
      case (kind_c)
        tnss_pkg::KIND_START: begin
          playing_next       = 1'b1;
          step_position_next = '0;
          frame_count_next   = 8'd0;
        end
        tnss_pkg::KIND_STOP: begin
          playing_next     = 1'b0;
          job_load         = 1'b1;
          job_silence_next = 1'b1;
        end
        tnss_pkg::KIND_LOAD: begin
          // Drop loads beyond the pattern depth
          mem_we = idx_x < MAX_X;
        end
        tnss_pkg::KIND_TICK: begin
          if (playing) begin
            if (frame_count == 8'd0 && at_end && !loop_enable) begin
              // Pattern end without loop: silence both, stop, frame count holds
              playing_next     = 1'b0;
              job_load         = 1'b1;
              job_silence_next = 1'b1;
            end else begin
              frame_count_next = fc_wrap;
              if (frame_count == 8'd0) begin
                // Step boundary: fetch this step (rewound on loop) and advance
                rd_en              = 1'b1;
                job_load           = 1'b1;
                step_position_next = rd_pos + PW'(1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      playing       <= 1'b0;
      step_position <= '0;
      frame_count   <= 8'd0;
      job_valid     <= 1'b0;
      job_silence   <= 1'b0;
    end else begin
      playing       <= playing_next;
      step_position <= step_position_next;
      frame_count   <= frame_count_next;
      if (in_accept) begin
        job_valid   <= job_load;
        job_silence <= job_silence_next;
      end else if (job_done) begin
        job_valid <= 1'b0;
      end
    end
  end

  // Pattern memories: one write port for loads, one registered read for ticks.
  // Read data is only refreshed when a new step job enters, so it holds while stalled.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      lead_mem[wr_addr] <= lead_note;
      bass_mem[wr_addr] <= bass_note;
    end
    if (rd_en) begin
      lead_rd <= lead_mem[rd_addr];
      bass_rd <= bass_mem[rd_addr];
    end
  end

  // A silence job sends note 0 on both channels; a step job sends the fetched notes
  assign job.lead = job_silence ? tnss_pkg::NOTE_SILENT : lead_rd;
  assign job.bass = job_silence ? tnss_pkg::NOTE_SILENT : bass_rd;

  tnss_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job),
    .job_done  (job_done),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .channel   (channel),
    .sounding  (sounding),
    .freq_code (freq_code),
    .last      (last)
  );

`ifndef SYNTHESIS
  a_play_needs_start: assert property (@(posedge clk) disable iff (rst)
    !playing && !(in_accept && kind_c == tnss_pkg::KIND_START) |=> !playing)
    else $error("playback began without a start item");

  a_pos_in_range: assert property (@(posedge clk) disable iff (rst)
    XW'(step_position) <= MAX_X)
    else $error("step position beyond pattern depth");

  a_idle_holds_counters: assert property (@(posedge clk) disable iff (rst)
    !in_accept |=> $stable(frame_count) && $stable(step_position))
    else $error("counters moved without an accepted item");

  a_stop_makes_silence: assert property (@(posedge clk) disable iff (rst)
    in_accept && kind_c == tnss_pkg::KIND_STOP |=> job_valid && job_silence && !playing)
    else $error("stop item did not queue silence");
`endif

endmodule
